[rtl/core/obpl_pkg.sv]
package obpl_pkg;

  localparam int LEVELS     = 64;
  localparam int PRICE_BITS = 32;
  localparam int QTY_BITS   = 31;
  localparam int LVL_W      = $clog2(LEVELS);
  localparam int CNT_W      = $clog2(LEVELS + 1);
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_ADDED   = 3'd0,
    ACT_UPDATED = 3'd1,
    ACT_REMOVED = 3'd2,
    ACT_IGNORED = 3'd3,
    ACT_FULL    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_UPDATE,
    OP_REMOVE
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                  side;
    logic [PRICE_BITS-1:0] price_ticks;
    logic [QTY_BITS-1:0]   quantity;
  } in_word_t;

  typedef struct packed {
    action_e               action;
    logic                  level_is_best;
    logic                  best_bid_valid;
    logic [PRICE_BITS-1:0] best_bid_price;
    logic [QTY_BITS-1:0]   best_bid_qty;
    logic                  best_ask_valid;
    logic [PRICE_BITS-1:0] best_ask_price;
    logic [QTY_BITS-1:0]   best_ask_qty;
  } out_word_t;

  typedef struct packed {
    logic                  found;
    logic                  match_best;
    logic                  ins_best;
    logic                  full;
    logic                  nonempty;
    logic [PRICE_BITS-1:0] best_price;
    logic [QTY_BITS-1:0]   best_qty;
  } side_stat_t;

endpackage

[rtl/core/obpl_side.sv]
module obpl_side (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           is_ask_i,
  input  logic                           cmp_en_i,
  input  logic [obpl_pkg::PRICE_BITS-1:0] price_i,
  input  logic [obpl_pkg::QTY_BITS-1:0]   qty_i,
  input  obpl_pkg::op_e                   op_i,
  output obpl_pkg::side_stat_t            stat_o
);
  import obpl_pkg::*;

  logic [PRICE_BITS-1:0] price_q [LEVELS];
  logic [PRICE_BITS-1:0] price_d [LEVELS];
  logic [QTY_BITS-1:0]   qty_q   [LEVELS];
  logic [QTY_BITS-1:0]   qty_d   [LEVELS];
  logic [CNT_W-1:0]      count_q, count_d;
  logic [LEVELS-1:0]     match_q, match_d;
  logic [LEVELS-1:0]     ahead_q, ahead_d;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      if (CNT_W'(i) < count_q) begin
        match_d[i] = (price_q[i] == price_i);
        ahead_d[i] = is_ask_i ? (price_i < price_q[i]) : (price_i > price_q[i]);
      end else begin
        match_d[i] = 1'b0;
        ahead_d[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
      ahead_q <= '0;
    end else if (cmp_en_i) begin
      match_q <= match_d;
      ahead_q <= ahead_d;
    end
  end

  always_comb begin
    count_d = count_q;
    for (int i = 0; i < LEVELS; i++) begin
      price_d[i] = price_q[i];
      qty_d[i]   = qty_q[i];
      case (op_i)
        OP_INSERT: begin
          if (ahead_q[i]) begin
            if (i == 0 || !ahead_q[(i == 0) ? 0 : i-1]) begin
              price_d[i] = price_i;
              qty_d[i]   = qty_i;
            end else begin
              price_d[i] = price_q[(i == 0) ? 0 : i-1];
              qty_d[i]   = qty_q[(i == 0) ? 0 : i-1];
            end
          end
        end
        OP_REMOVE: begin
          if ((match_q[i] || ahead_q[i]) && i < LEVELS-1) begin
            price_d[i] = price_q[(i == LEVELS-1) ? i : i+1];
            qty_d[i]   = qty_q[(i == LEVELS-1) ? i : i+1];
          end
        end
        OP_UPDATE: begin
          if (match_q[i]) qty_d[i] = qty_i;
        end
        default: ;
      endcase
    end
    if (op_i == OP_INSERT) count_d = count_q + 1'b1;
    if (op_i == OP_REMOVE) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LEVELS; i++) begin
      price_q[i] <= price_d[i];
      qty_q[i]   <= qty_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else         count_q <= count_d;
  end

  always_comb begin
    stat_o.found      = |match_q;
    stat_o.match_best = match_q[0];
    stat_o.ins_best   = ahead_q[0];
    stat_o.full       = (count_q == CNT_W'(LEVELS));
    stat_o.nonempty   = (count_q != '0);
    stat_o.best_price = stat_o.nonempty ? price_q[0] : '0;
    stat_o.best_qty   = stat_o.nonempty ? qty_q[0] : '0;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LEVELS)) else $error("level count past table size");

  a_insert_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_INSERT |-> !stat_o.full) else $error("insert into full table");

  a_remove_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_REMOVE || op_i == OP_UPDATE) |-> stat_o.found)
    else $error("remove or update without a match");

endmodule

[rtl/core/obpl_back.sv]
module obpl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  obpl_pkg::in_word_t  q_word_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output obpl_pkg::out_word_t out_word_o
);
  import obpl_pkg::*;

  state_e     state_q, state_d;
  in_word_t   item_q;
  action_e    act_q, act_d;
  logic       best_q, best_d;
  op_e        op_d;
  op_e        bid_op, ask_op;
  side_stat_t bid_stat, ask_stat, sel_stat;
  logic       cmp_en;
  logic       out_load;
  logic       out_valid_q;
  out_word_t  out_q;

  obpl_side u_bid (
    .clk_i, .rst_ni, .is_ask_i(1'b0), .cmp_en_i(cmp_en),
    .price_i(item_q.price_ticks), .qty_i(item_q.quantity),
    .op_i(bid_op), .stat_o(bid_stat)
  );

  obpl_side u_ask (
    .clk_i, .rst_ni, .is_ask_i(1'b1), .cmp_en_i(cmp_en),
    .price_i(item_q.price_ticks), .qty_i(item_q.quantity),
    .op_i(ask_op), .stat_o(ask_stat)
  );

  assign sel_stat = item_q.side ? ask_stat : bid_stat;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (q_valid_i) state_d = ST_CMP;
      ST_CMP:   state_d = ST_APPLY;
      ST_APPLY: state_d = ST_EMIT;
      ST_EMIT:  if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    act_d  = act_q;
    best_d = best_q;
    op_d   = OP_NONE;
    if (sel_stat.found) begin
      best_d = sel_stat.match_best;
      if (item_q.quantity == '0) begin
        act_d = ACT_REMOVED;
        op_d  = OP_REMOVE;
      end else begin
        act_d = ACT_UPDATED;
        op_d  = OP_UPDATE;
      end
    end else if (item_q.quantity == '0) begin
      act_d  = ACT_IGNORED;
      best_d = 1'b0;
    end else if (sel_stat.full) begin
      act_d  = ACT_FULL;
      best_d = 1'b0;
    end else begin
      act_d  = ACT_ADDED;
      best_d = sel_stat.ins_best;
      op_d   = OP_INSERT;
    end
  end

  always_comb begin
    q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
    cmp_en   = (state_q == ST_CMP);
    bid_op   = (state_q == ST_APPLY && !item_q.side) ? op_d : OP_NONE;
    ask_op   = (state_q == ST_APPLY &&  item_q.side) ? op_d : OP_NONE;
    out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) item_q <= q_word_i;
    if (state_q == ST_APPLY) begin
      act_q  <= act_d;
      best_q <= best_d;
    end
    if (out_load) begin
      out_q.action         <= act_q;
      out_q.level_is_best  <= best_q;
      out_q.best_bid_valid <= bid_stat.nonempty;
      out_q.best_bid_price <= bid_stat.best_price;
      out_q.best_bid_qty   <= bid_stat.best_qty;
      out_q.best_ask_valid <= ask_stat.nonempty;
      out_q.best_ask_price <= ask_stat.best_price;
      out_q.best_ask_qty   <= ask_stat.best_qty;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q) else $error("result not registered");

  a_cmp_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == ST_CMP) else $error("pop without compare");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result word changed");

endmodule

[rtl/core/order_book_price_levels_core.sv]
// Order book price-level table: bid and ask levels kept sorted, best first.
// Input channel: in_valid_i / in_stall_o carry one word {side, price_ticks,
// quantity}. Zero quantity removes a matching level; nonzero updates or inserts.
// Output channel: out_valid_o / out_stall_i carry one result word per input
// word, in order: the action, whether the touched level was best, and the
// best bid and best ask after the change.
// A two-word queue takes input words while the table engine works.
// Each word passes through the engine in order: dequeue, compare against every
// level at once, shift/update the level row, register the result. The engine
// takes the next word from the queue only after the result is registered.
// Reset empties both tables and the queue; no clearing pass is needed.
// While the receiver stalls, the result register holds its word; the engine
// finishes the next word and waits, and the queue fills, then in_stall_o rises.
module order_book_price_levels_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  obpl_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output obpl_pkg::out_word_t out_word_o
);
  import obpl_pkg::*;

  in_word_t             q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   cnt_q;
  logic                 push, pop, q_valid;

  assign in_stall_o = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid    = (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (!push && pop) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= in_word_i;
  end

  obpl_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_word_i(q_mem[rd_ptr_q]), .q_pop_o(pop),
    .out_valid_o, .out_stall_i, .out_word_o
  );

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH)) else $error("queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid) else $error("pop from empty queue");

  a_pop_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !pop) else $error("pop on back-to-back cycles");

endmodule
